FILE: hw/rtl/buddy_page_allocator_defines.svh
// ----------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define BPA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bpa assertion failed");
`define BPA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bpa assertion failed");
`else
`define BPA_ASSERT(label, clk, rst, prop)
`define BPA_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Sizes, codes and item structures shared by the allocator modules.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int ORDERS     = 11;
  localparam int POOL_PAGES = 4096;
  localparam int IDX_W      = 12;
  localparam int ORD_W      = 4;
  localparam int ALLOC_W    = 5;
  localparam int CNT_W      = 13;
  localparam int REQ_W      = 16;
  localparam int SCAN_W     = IDX_W + 1;

  localparam logic [ORD_W-1:0]   NO_FREE_HEAD  = 4'd15;
  localparam logic [ALLOC_W-1:0] NO_ALLOC_HEAD = 5'd31;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_SIZE    = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } func_t;

  typedef struct packed {
    func_t             func;
    logic [REQ_W-1:0]  request_pages;
    logic [IDX_W-1:0]  page_index;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  block_index;
    logic [ORD_W-1:0]  block_order;
  } res_t;

endpackage

FILE: hw/rtl/bpa_core.sv
// ----------------------------------------------------------------------------
// Buddy page allocator core
// Sequencer over the free-head and alloc-order memories and per-order counts.
// ----------------------------------------------------------------------------
`include "buddy_page_allocator_defines.svh"

module bpa_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  bpa_pkg::req_t req,
  output logic          ready,
  output logic          done,
  input  logic          take,
  output bpa_pkg::res_t res
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_F_CHK, S_F_BUD, S_F_BCHK, S_F_FIN,
    S_A_CNT, S_A_SCAN, S_A_TAKE, S_A_SPLIT, S_DONE
  } state_t;

  state_t state;

  logic [bpa_pkg::IDX_W-1:0]  idx;
  logic [bpa_pkg::ORD_W-1:0]  ord;
  logic [bpa_pkg::ORD_W-1:0]  want;
  logic [bpa_pkg::SCAN_W-1:0] scan;
  logic                       rd_vld;
  logic [bpa_pkg::IDX_W-1:0]  rd_addr;
  logic [bpa_pkg::CNT_W-1:0]  cnt [bpa_pkg::ORDERS];

  logic [bpa_pkg::ORD_W-1:0]   fho_mem [bpa_pkg::POOL_PAGES];
  logic [bpa_pkg::ALLOC_W-1:0] ao_mem  [bpa_pkg::POOL_PAGES];
  logic [bpa_pkg::ORD_W-1:0]   fho_q;
  logic [bpa_pkg::ALLOC_W-1:0] ao_q;

  logic                        fho_we, fho_re, ao_we, ao_re;
  logic [bpa_pkg::IDX_W-1:0]   fho_wa, fho_ra, ao_wa, ao_ra;
  logic [bpa_pkg::ORD_W-1:0]   fho_wd;
  logic [bpa_pkg::ALLOC_W-1:0] ao_wd;

  logic [bpa_pkg::REQ_W-1:0]   req_m1;
  logic [4:0]                  want_c;
  logic                        size_err;
  logic [bpa_pkg::IDX_W-1:0]   ord_bit, buddy, split_addr;
  logic [bpa_pkg::ORD_W-1:0]   ord_dn;
  logic                        scan_end, buddy_out, top_order;

  always_comb begin
    req_m1 = req.request_pages - 1'b1;
    want_c = 5'd0;
    for (int i = 0; i < bpa_pkg::REQ_W; i++) begin
      if (req_m1[i]) want_c = 5'(i + 1);
    end
    size_err = (req.request_pages == '0) || (want_c >= 5'(bpa_pkg::ORDERS));
    ord_bit    = bpa_pkg::IDX_W'(1) << ord;
    buddy      = idx ^ ord_bit;
    ord_dn     = ord - 1'b1;
    split_addr = idx + (bpa_pkg::IDX_W'(1) << ord_dn);
    scan_end   = scan == bpa_pkg::SCAN_W'(bpa_pkg::POOL_PAGES);
    buddy_out  = {1'b0, buddy} >= bpa_pkg::SCAN_W'(bpa_pkg::POOL_PAGES);
    top_order  = (5'(ord) + 5'd1) >= 5'(bpa_pkg::ORDERS);
  end

  always_comb begin
    fho_we = 1'b0; fho_wa = idx; fho_wd = bpa_pkg::NO_FREE_HEAD;
    fho_re = 1'b0; fho_ra = buddy;
    ao_we  = 1'b0; ao_wa  = idx; ao_wd  = bpa_pkg::NO_ALLOC_HEAD;
    ao_re  = 1'b0; ao_ra  = req.page_index;
    case (state)
      S_CLEAR: begin
        fho_we = 1'b1; fho_wa = scan[bpa_pkg::IDX_W-1:0];
        ao_we  = 1'b1; ao_wa  = scan[bpa_pkg::IDX_W-1:0]; ao_wd = '0;
      end
      S_IDLE:   ao_re = start && (req.func == bpa_pkg::FN_FREE);
      S_F_CHK:  ao_we = ao_q < bpa_pkg::ALLOC_W'(bpa_pkg::ORDERS);
      S_F_BUD:  fho_re = !(top_order || buddy_out);
      S_F_BCHK: begin
        fho_we = fho_q == ord; fho_wa = buddy;
      end
      S_F_FIN: begin
        fho_we = 1'b1; fho_wd = ord;
      end
      S_A_SCAN: begin
        fho_re = !scan_end; fho_ra = scan[bpa_pkg::IDX_W-1:0];
      end
      S_A_TAKE: begin
        fho_we = 1'b1;
        ao_we = 1'b1; ao_wd = bpa_pkg::ALLOC_W'(want);
      end
      S_A_SPLIT: begin
        fho_we = ord > want; fho_wa = split_addr; fho_wd = ord_dn;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fho_we) fho_mem[fho_wa] <= fho_wd;
    if (fho_re) fho_q <= fho_mem[fho_ra];
  end

  always_ff @(posedge clk) begin
    if (ao_we) ao_mem[ao_wa] <= ao_wd;
    if (ao_re) ao_q <= ao_mem[ao_ra];
  end

  assign ready = state == S_IDLE;
  assign done  = state == S_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      scan   <= '0;
      rd_vld <= 1'b0;
      for (int i = 0; i < bpa_pkg::ORDERS; i++) cnt[i] <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          scan <= scan + 1'b1;
          if (scan[bpa_pkg::IDX_W-1:0] == bpa_pkg::IDX_W'(bpa_pkg::POOL_PAGES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            idx <= req.page_index;
            res.block_index <= '0;
            res.block_order <= '0;
            if (req.func == bpa_pkg::FN_FREE) begin
              state <= S_F_CHK;
            end else if (size_err) begin
              res.status <= bpa_pkg::ST_SIZE;
              state <= S_DONE;
            end else begin
              want  <= want_c[bpa_pkg::ORD_W-1:0];
              ord   <= want_c[bpa_pkg::ORD_W-1:0];
              state <= S_A_CNT;
            end
          end
        end
        S_F_CHK: begin
          if (ao_q >= bpa_pkg::ALLOC_W'(bpa_pkg::ORDERS)) begin
            res.status <= bpa_pkg::ST_BADFREE;
            state <= S_DONE;
          end else begin
            ord   <= ao_q[bpa_pkg::ORD_W-1:0];
            state <= S_F_BUD;
          end
        end
        S_F_BUD: state <= (top_order || buddy_out) ? S_F_FIN : S_F_BCHK;
        S_F_BCHK: begin
          if (fho_q == ord) begin
            cnt[ord] <= cnt[ord] - 1'b1;
            idx   <= idx & buddy;
            ord   <= ord + 1'b1;
            state <= S_F_BUD;
          end else begin
            state <= S_F_FIN;
          end
        end
        S_F_FIN: begin
          cnt[ord] <= cnt[ord] + 1'b1;
          res.status      <= bpa_pkg::ST_OK;
          res.block_index <= idx;
          res.block_order <= ord;
          state <= S_DONE;
        end
        S_A_CNT: begin
          if (ord >= bpa_pkg::ORD_W'(bpa_pkg::ORDERS)) begin
            res.status <= bpa_pkg::ST_EMPTY;
            state <= S_DONE;
          end else if (cnt[ord] == '0) begin
            ord <= ord + 1'b1;
          end else begin
            scan   <= '0;
            rd_vld <= 1'b0;
            state  <= S_A_SCAN;
          end
        end
        S_A_SCAN: begin
          rd_vld  <= !scan_end;
          rd_addr <= scan[bpa_pkg::IDX_W-1:0];
          if (!scan_end) scan <= scan + 1'b1;
          if (rd_vld && fho_q == ord) begin
            idx   <= rd_addr;
            state <= S_A_TAKE;
          end else if (!rd_vld && scan_end) begin
            ord   <= ord + 1'b1;
            state <= S_A_CNT;
          end
        end
        S_A_TAKE: begin
          cnt[ord] <= cnt[ord] - 1'b1;
          state <= S_A_SPLIT;
        end
        S_A_SPLIT: begin
          if (ord > want) begin
            cnt[ord_dn] <= cnt[ord_dn] + 1'b1;
            ord <= ord_dn;
          end else begin
            res.status      <= bpa_pkg::ST_OK;
            res.block_index <= idx;
            res.block_order <= want;
            state <= S_DONE;
          end
        end
        S_DONE: if (take) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `BPA_ASSERT(a_err_zero, clk, rst, (done && res.status != bpa_pkg::ST_OK) |-> (res.block_index == '0 && res.block_order == '0))
  `BPA_ASSERT(a_split_bound, clk, rst, (state == S_A_SPLIT) |-> (ord >= want))
  `BPA_ASSERT(a_merge_bound, clk, rst, (state == S_F_BUD) |-> (ord < bpa_pkg::ORD_W'(bpa_pkg::ORDERS)))

endmodule

FILE: hw/rtl/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// Buddy page allocator
// Allocates and frees power-of-two page blocks over a 4096-page pool.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                        | tuser
// s_      | in  | request_pages[15:0], page_index[27:16]    | func
// m_      | out | status[1:0], block_index[13:2], order[17:14] | -
// After reset a clearing pass over all 4096 pages runs with s_tready low.
// Free: checks the recorded order, merges one order at a time (up to 10 merges)
// and stops at a buddy that is not free; one memory read per probe.
// Alloc: checks the count of each order from the wanted one up, runs a
// lowest-index scan of the free-head memory, and splits down to the wanted order.
// A result waits in the output register until taken; the core holds a new result until that register is free.
`include "buddy_page_allocator_defines.svh"

module buddy_page_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // request_pages, page_index, zero pad
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // status, block_index, block_order, zero pad
);

  bpa_pkg::req_t req;
  bpa_pkg::res_t res;
  logic          start, ready, done, take;

  assign req.func          = bpa_pkg::func_t'(s_tuser);
  assign req.request_pages = s_tdata[15:0];
  assign req.page_index    = s_tdata[27:16];
  assign s_tready          = ready;
  assign start             = s_tvalid && ready;
  assign take              = !m_tvalid || m_tready;

  bpa_core u_core (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .ready (ready),
    .done  (done),
    .take  (take),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done && take) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {6'd0, res.block_order, res.block_index, res.status};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  `BPA_ASSERT(a_no_start_busy, clk, rst, start |-> !done)
  `BPA_ASSERT(a_out_after_done, clk, rst, (done && take) |=> m_tvalid)
  `BPA_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (!m_tvalid && !s_tready))

endmodule
